// ===== sv/text_console_writer_defines.svh =====
// ----------------------------------------------------------------------------
// text_console_writer_defines
// Assertion macros shared by the text console writer RTL.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define TCW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("text console writer: same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent
`define TCW_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("text console writer: next-cycle check failed");

`endif

// ===== sv/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  // Port payload widths
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned RADDR_W  = 12;
  localparam int unsigned DATA_W   = 16;
  localparam int unsigned OFFSET_W = 11;
  localparam int unsigned STYLE_W  = 8;

  // Opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_BS     = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_FF     = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_CTRL_V = 8'h16;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;

  // Style after reset
  localparam logic [STYLE_W-1:0] STYLE_RESET = 8'h07;

  // Sequencer states
  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_RDWAIT = 7'b0000100,
    ST_CHECK  = 7'b0001000,
    ST_COPY   = 7'b0010000,
    ST_BLANK  = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_e;

  // Actions decoded from one written byte
  typedef struct packed {
    logic put;
    logic ff;
    logic set_lit;
  } cmd_t;

endpackage

`default_nettype wire

// ===== sv/tcw_if.sv =====
// ----------------------------------------------------------------------------
// tcw_if
// Valid/ready channels of the text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcw_item_if;
  logic                             valid;
  logic                             ready;
  logic                             opcode;
  logic [tcw_pkg::CHAR_W-1:0]       char_byte;
  logic [tcw_pkg::RADDR_W-1:0]      read_address;
  modport source (output valid, opcode, char_byte, read_address, input ready);
  modport sink   (input valid, opcode, char_byte, read_address, output ready);
endinterface

interface tcw_result_if;
  logic                             valid;
  logic                             ready;
  logic [tcw_pkg::DATA_W-1:0]       read_data;
  logic [tcw_pkg::OFFSET_W-1:0]     cursor_offset;
  logic [tcw_pkg::OFFSET_W-1:0]     display_start;
  modport source (output valid, read_data, cursor_offset, display_start, input ready);
  modport sink   (input valid, read_data, cursor_offset, display_start, output ready);
endinterface

interface tcw_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [tcw_pkg::STYLE_W-1:0]      text_style;
  modport source (output valid, text_style, input ready);
  modport sink   (input valid, text_style, output ready);
endinterface

`default_nettype wire

// ===== sv/tcw_cursor.sv =====
// ----------------------------------------------------------------------------
// tcw_cursor
// Decodes one written byte and computes the next cursor column, row and
// tab phase (column modulo the tab stop).
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_cursor #(
  parameter int unsigned COLUMNS  = 80,
  parameter int unsigned TAB_STOP = 8,
  parameter int unsigned CW       = 7,
  parameter int unsigned RW       = 5,
  parameter int unsigned PW       = 4
) (
  input  wire logic [tcw_pkg::CHAR_W-1:0] char_byte_i,
  input  wire logic                       lit_i,
  input  wire logic [CW-1:0]              col_i,
  input  wire logic [RW-1:0]              row_i,
  input  wire logic [PW-1:0]              phase_i,
  output logic [CW-1:0]                   col_o,
  output logic [RW-1:0]                   row_o,
  output logic [PW-1:0]                   phase_o,
  output tcw_pkg::cmd_t                   cmd_o
);

  localparam int unsigned TW = $clog2(2 * COLUMNS + TAB_STOP + 1);
  localparam int unsigned P_BS = (COLUMNS - 1) % TAB_STOP;
  localparam int unsigned P_W1 = (TAB_STOP - (COLUMNS % TAB_STOP)) % TAB_STOP;
  localparam int unsigned P_W2 = (TAB_STOP - ((2 * COLUMNS) % TAB_STOP)) % TAB_STOP;

  logic [TW-1:0] tab_col;

  // Next column for a tab, before wrapping
  assign tab_col = TW'(col_i) + TW'(TAB_STOP) - TW'(phase_i);

  // Decode the byte and move the cursor
  always_comb begin
    col_o   = col_i;
    row_o   = row_i;
    phase_o = phase_i;
    cmd_o   = '0;
    if (lit_i) begin
      cmd_o.put = 1'b1;
    end else begin
      case (char_byte_i)
        tcw_pkg::CH_BS: begin
          if (col_i != '0) begin
            col_o   = col_i - CW'(1);
            phase_o = (phase_i == '0) ? PW'(TAB_STOP - 1) : phase_i - PW'(1);
          end else if (row_i != '0) begin
            row_o   = row_i - RW'(1);
            col_o   = CW'(COLUMNS - 1);
            phase_o = PW'(P_BS);
          end
        end
        tcw_pkg::CH_CR: begin
          col_o   = '0;
          phase_o = '0;
        end
        tcw_pkg::CH_LF: begin
          col_o   = '0;
          phase_o = '0;
          row_o   = row_i + RW'(1);
        end
        tcw_pkg::CH_TAB: begin
          if (tab_col >= TW'(2 * COLUMNS)) begin
            col_o   = CW'(tab_col - TW'(2 * COLUMNS));
            row_o   = row_i + RW'(2);
            phase_o = PW'(P_W2);
          end else if (tab_col >= TW'(COLUMNS)) begin
            col_o   = CW'(tab_col - TW'(COLUMNS));
            row_o   = row_i + RW'(1);
            phase_o = PW'(P_W1);
          end else begin
            col_o   = CW'(tab_col);
            phase_o = '0;
          end
        end
        tcw_pkg::CH_FF: begin
          cmd_o.ff = 1'b1;
          row_o    = '0;
        end
        tcw_pkg::CH_CTRL_V: begin
          cmd_o.set_lit = 1'b1;
        end
        default: begin
          cmd_o.put = 1'b1;
        end
      endcase
    end

    // Advance after a printed character
    if (cmd_o.put) begin
      if (col_i == CW'(COLUMNS - 1)) begin
        col_o   = '0;
        row_o   = row_i + RW'(1);
        phase_o = '0;
      end else begin
        col_o   = col_i + CW'(1);
        phase_o = (phase_i == PW'(TAB_STOP - 1)) ? '0 : phase_i + PW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/text_console_writer.sv =====
// Sequence: a character passes CHECK and DONE before its result is registered, a read
// passes RDWAIT and DONE; a scroll adds a BLANK sweep of one line, a page copy back to
// cell 0 adds a COPY sweep of one page before it, and form feed adds COPY and BLANK sweeps.
// Throughput: one item at a time; a new item is accepted only when the sequencer is idle.
// Reset: control state clears at once, then a clearing pass writes zero to all
// 2*COLUMNS*ROWS cells, one per cycle, while no item is accepted.
// ----------------------------------------------------------------------------
// text_console_writer
// Text terminal that keeps a two-page cell memory, a cursor and a display start.
// ----------------------------------------------------------------------------
`default_nettype none
`include "text_console_writer_defines.svh"

module text_console_writer #(
  parameter int unsigned COLUMNS  = 80,
  parameter int unsigned ROWS     = 25,
  parameter int unsigned TAB_STOP = 8
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  tcw_item_if.sink      item_i,
  tcw_result_if.source  result_o,
  tcw_cfg_if.sink       cfg_i
);

  localparam int unsigned PAGE_CELLS = COLUMNS * ROWS;
  localparam int unsigned MEM_CELLS  = 2 * PAGE_CELLS;
  localparam int unsigned AW  = $clog2(MEM_CELLS);
  localparam int unsigned NW  = $clog2(MEM_CELLS + 1);
  localparam int unsigned CW  = $clog2(COLUMNS);
  localparam int unsigned RW  = $clog2(ROWS + 2);
  localparam int unsigned LW  = $clog2(ROWS + 1);
  localparam int unsigned PW  = $clog2(TAB_STOP + 1);

  // Cell memory
  logic [tcw_pkg::DATA_W-1:0] mem [MEM_CELLS];
  logic [tcw_pkg::DATA_W-1:0] rdata_q;
  logic                       mem_we, mem_re;
  logic [AW-1:0]              mem_waddr, mem_raddr;
  logic [tcw_pkg::DATA_W-1:0] mem_wdata;

  // Control state
  tcw_pkg::state_e state_q, state_d;
  logic [CW-1:0]   col_q, col_d;
  logic [RW-1:0]   row_q, row_d;
  logic [PW-1:0]   phase_q, phase_d;
  logic [LW-1:0]   top_q, top_d;
  logic            lit_q, lit_d;
  logic            ff_q, ff_d;
  logic            scroll_q, scroll_d;
  logic [AW-1:0]   src_q, src_d;
  logic [AW-1:0]   dst_q, dst_d;
  logic [NW-1:0]   rem_q, rem_d;
  logic            pend_q, pend_d;
  logic [AW-1:0]   paddr_q, paddr_d;
  logic            isread_q, isread_d;
  logic            inrange_q, inrange_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic [tcw_pkg::STYLE_W-1:0] style_q;

  // Result register
  logic                         out_valid_q, out_valid_d;
  logic [tcw_pkg::DATA_W-1:0]   out_data_q, out_data_d;
  logic [tcw_pkg::OFFSET_W-1:0] out_cur_q, out_cur_d;
  logic [tcw_pkg::OFFSET_W-1:0] out_disp_q, out_disp_d;

  // Cursor decode
  logic [CW-1:0]  nx_col;
  logic [RW-1:0]  nx_row;
  logic [PW-1:0]  nx_phase;
  tcw_pkg::cmd_t  cmd;
  logic           acc;
  logic           addr_ok;
  logic [AW-1:0]  line_base;

  tcw_cursor #(
    .COLUMNS  (COLUMNS),
    .TAB_STOP (TAB_STOP),
    .CW       (CW),
    .RW       (RW),
    .PW       (PW)
  ) u_cursor (
    .char_byte_i (item_i.char_byte),
    .lit_i       (lit_q),
    .col_i       (col_q),
    .row_i       (row_q),
    .phase_i     (phase_q),
    .col_o       (nx_col),
    .row_o       (nx_row),
    .phase_o     (nx_phase),
    .cmd_o       (cmd)
  );

  assign item_i.ready = (state_q == tcw_pkg::ST_IDLE);
  assign acc          = item_i.valid && item_i.ready;
  assign cfg_i.ready  = 1'b1;
  assign addr_ok      = (32'(item_i.read_address) < MEM_CELLS);
  assign line_base    = (AW'(top_q) + AW'(row_q)) * AW'(COLUMNS);

  assign result_o.valid         = out_valid_q;
  assign result_o.read_data     = out_data_q;
  assign result_o.cursor_offset = out_cur_q;
  assign result_o.display_start = out_disp_q;

  // Select the memory ports
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = src_q;
    case (state_q)
      tcw_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
      end
      tcw_pkg::ST_IDLE: begin
        if (acc && item_i.opcode == tcw_pkg::OP_READ && addr_ok) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(item_i.read_address);
        end
        if (acc && item_i.opcode == tcw_pkg::OP_WRITE && cmd.put) begin
          mem_we    = 1'b1;
          mem_waddr = line_base + AW'(col_q);
          mem_wdata = {style_q, item_i.char_byte};
        end
      end
      tcw_pkg::ST_COPY: begin
        mem_re    = (rem_q != '0);
        mem_we    = pend_q;
        mem_waddr = paddr_q;
        mem_wdata = rdata_q;
      end
      tcw_pkg::ST_BLANK: begin
        mem_we    = (rem_q != '0);
        mem_waddr = dst_q;
        mem_wdata = {style_q, tcw_pkg::CH_SPACE};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Memory array with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // Sequence one item
  always_comb begin
    state_d    = state_q;
    col_d      = col_q;
    row_d      = row_q;
    phase_d    = phase_q;
    top_d      = top_q;
    lit_d      = lit_q;
    ff_d       = ff_q;
    scroll_d   = scroll_q;
    src_d      = src_q;
    dst_d      = dst_q;
    rem_d      = rem_q;
    pend_d     = pend_q;
    paddr_d    = paddr_q;
    isread_d   = isread_q;
    inrange_d  = inrange_q;
    clr_d      = clr_q;
    out_valid_d = out_valid_q && !result_o.ready;
    out_data_d  = out_data_q;
    out_cur_d   = out_cur_q;
    out_disp_d  = out_disp_q;
    case (state_q)
      tcw_pkg::ST_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(MEM_CELLS - 1)) begin
          state_d = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_IDLE: begin
        if (acc) begin
          if (item_i.opcode == tcw_pkg::OP_READ) begin
            isread_d  = 1'b1;
            inrange_d = addr_ok;
            state_d   = tcw_pkg::ST_RDWAIT;
          end else begin
            isread_d = 1'b0;
            col_d    = nx_col;
            row_d    = nx_row;
            phase_d  = nx_phase;
            lit_d    = cmd.set_lit;
            if (cmd.ff) begin
              top_d   = '0;
              src_d   = line_base;
              dst_d   = '0;
              rem_d   = NW'(COLUMNS);
              pend_d  = 1'b0;
              ff_d    = 1'b1;
              state_d = tcw_pkg::ST_COPY;
            end else begin
              state_d = tcw_pkg::ST_CHECK;
            end
          end
        end
      end
      tcw_pkg::ST_RDWAIT: begin
        state_d = tcw_pkg::ST_DONE;
      end
      tcw_pkg::ST_CHECK: begin
        if (row_q >= RW'(ROWS) || scroll_q) begin
          row_d = RW'(ROWS - 1);
          if (top_q == LW'(ROWS)) begin
            src_d    = AW'(PAGE_CELLS);
            dst_d    = '0;
            rem_d    = NW'(PAGE_CELLS);
            pend_d   = 1'b0;
            top_d    = '0;
            scroll_d = 1'b1;
            state_d  = tcw_pkg::ST_COPY;
          end else begin
            top_d    = top_q + LW'(1);
            dst_d    = (AW'(top_q) + AW'(ROWS)) * AW'(COLUMNS);
            rem_d    = NW'(COLUMNS);
            scroll_d = 1'b0;
            state_d  = tcw_pkg::ST_BLANK;
          end
        end else begin
          state_d = tcw_pkg::ST_DONE;
        end
      end
      tcw_pkg::ST_COPY: begin
        if (rem_q != '0) begin
          src_d   = src_q + AW'(1);
          dst_d   = dst_q + AW'(1);
          rem_d   = rem_q - NW'(1);
          pend_d  = 1'b1;
          paddr_d = dst_q;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            if (ff_q) begin
              ff_d    = 1'b0;
              dst_d   = AW'(COLUMNS);
              rem_d   = NW'(PAGE_CELLS - COLUMNS);
              state_d = tcw_pkg::ST_BLANK;
            end else begin
              state_d = tcw_pkg::ST_CHECK;
            end
          end
        end
      end
      tcw_pkg::ST_BLANK: begin
        if (rem_q != '0) begin
          dst_d = dst_q + AW'(1);
          rem_d = rem_q - NW'(1);
        end else begin
          state_d = tcw_pkg::ST_DONE;
        end
      end
      tcw_pkg::ST_DONE: begin
        if (!out_valid_q || result_o.ready) begin
          out_valid_d = 1'b1;
          out_data_d  = (isread_q && inrange_q) ? rdata_q : '0;
          out_cur_d   = tcw_pkg::OFFSET_W'(AW'(row_q) * AW'(COLUMNS) + AW'(col_q));
          out_disp_d  = tcw_pkg::OFFSET_W'(AW'(top_q) * AW'(COLUMNS));
          state_d     = tcw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcw_pkg::ST_CLEAR;
      col_q       <= '0;
      row_q       <= '0;
      phase_q     <= '0;
      top_q       <= '0;
      lit_q       <= 1'b0;
      ff_q        <= 1'b0;
      scroll_q    <= 1'b0;
      rem_q       <= '0;
      pend_q      <= 1'b0;
      isread_q    <= 1'b0;
      inrange_q   <= 1'b0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      style_q     <= tcw_pkg::STYLE_RESET;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      phase_q     <= phase_d;
      top_q       <= top_d;
      lit_q       <= lit_d;
      ff_q        <= ff_d;
      scroll_q    <= scroll_d;
      rem_q       <= rem_d;
      pend_q      <= pend_d;
      isread_q    <= isread_d;
      inrange_q   <= inrange_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        style_q <= cfg_i.text_style;
      end
    end
  end

  // Hold addresses and result payload
  always_ff @(posedge clk_i) begin
    src_q      <= src_d;
    dst_q      <= dst_d;
    paddr_q    <= paddr_d;
    out_data_q <= out_data_d;
    out_cur_q  <= out_cur_d;
    out_disp_q <= out_disp_d;
  end

  // Checks
  `TCW_ASSERT_IMP(a_row_in_page, state_q == tcw_pkg::ST_IDLE, row_q < RW'(ROWS))
  `TCW_ASSERT_IMP(a_top_bound, 1'b1, top_q <= LW'(ROWS))
  `TCW_ASSERT_IMP(a_copy_write, pend_q, state_q == tcw_pkg::ST_COPY)
  `TCW_ASSERT_NXT(a_busy_after_accept, acc, state_q != tcw_pkg::ST_IDLE)

endmodule

`default_nettype wire
